// ===== hw/rtl/aavr_pkg.sv =====
`default_nettype none
package aavr_pkg;
  localparam int AtanEntries = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629713;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] r;
    r = '0;
    unique case (i)
      0: r = 34'sh3243F6A8;
      1: r = 34'sh1DAC6705;
      2: r = 34'sh0FADBAFC;
      3: r = 34'sh07F56EA6;
      4: r = 34'sh03FEAB76;
      5: r = 34'sh01FFD55B;
      6: r = 34'sh00FFFAAA;
      7: r = 34'sh007FFF55;
      8: r = 34'sh003FFFEA;
      9: r = 34'sh001FFFFD;
      10: r = 34'sh000FFFFF;
      11: r = 34'sh0007FFFF;
      12: r = 34'sh0003FFFF;
      13: r = 34'sh0001FFFF;
      14: r = 34'sh0000FFFF;
      15: r = 34'sh00007FFF;
      16: r = 34'sh00003FFF;
      17: r = 34'sh00001FFF;
      18: r = 34'sh00000FFF;
      19: r = 34'sh000007FF;
      20: r = 34'sh000003FF;
      21: r = 34'sh000001FF;
      22: r = 34'sh000000FF;
      23: r = 34'sh0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/axis_angle_vector_rotation.sv =====
// Rodrigues rotation of a vector about a Q1.14 axis by a Q3.13 angle. A request is taken
// on any cycle where start is high; busy is always low, so one request per cycle is
// sustained. Each result appears with done high for one cycle, after its request has passed
// one angle-fold stage, one stage per CORDIC iteration, then four multiply/add stages.
// The receiver cannot stall; results must be taken when shown.
`default_nettype none
module axis_angle_vector_rotation import aavr_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int VEC_WIDTH = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic signed [15:0] axis_x,
  input  wire logic signed [15:0] axis_y,
  input  wire logic signed [15:0] axis_z,
  input  wire logic signed [15:0] angle,
  input  wire logic signed [VEC_WIDTH-1:0] vec_x,
  input  wire logic signed [VEC_WIDTH-1:0] vec_y,
  input  wire logic signed [VEC_WIDTH-1:0] vec_z,
  output logic done,
  output logic signed [VEC_WIDTH-1:0] rot_x,
  output logic signed [VEC_WIDTH-1:0] rot_y,
  output logic signed [VEC_WIDTH-1:0] rot_z,
  output logic clipped
);
  localparam int N = CORDIC_STAGES;
  localparam int W = VEC_WIDTH;
  localparam int PW = W + 18;
  localparam int RW = W + 22;

  typedef struct packed {
    logic signed [2:0][15:0] z;
    logic signed [2:0][W-1:0] v;
  } item_t;

  assign busy = 1'b0;

  // stage 0: fold angle
  logic        v0;
  logic        flip0;
  logic signed [33:0] t0;
  item_t       it0;
  logic signed [33:0] ta;
  always_comb begin
    ta = 34'(angle) <<< 17;
  end
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start;
    it0.z <= {axis_z, axis_y, axis_x};
    it0.v <= {vec_z, vec_y, vec_x};
    if (ta > HalfPiQ30) begin
      t0 <= ta - PiQ30; flip0 <= 1'b1;
    end else if (ta < -HalfPiQ30) begin
      t0 <= ta + PiQ30; flip0 <= 1'b1;
    end else begin
      t0 <= ta; flip0 <= 1'b0;
    end
  end

  // cordic pipeline
  logic               cv [N+1];
  logic               cf [N+1];
  logic signed [33:0] ct [N+1];
  logic signed [33:0] cx [N+1];
  logic signed [33:0] cy [N+1];
  item_t              ci [N+1];
  always_comb begin
    cv[0] = v0; cf[0] = flip0; ct[0] = t0;
    cx[0] = CordicGain; cy[0] = '0; ci[0] = it0;
  end
  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [33:0] atn;
    assign atn = (i < AtanEntries) ? atan_q30(i) : 34'sd0;
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else cv[i+1] <= cv[i];
      cf[i+1] <= cf[i];
      ci[i+1] <= ci[i];
      if (i >= AtanEntries) begin
        cx[i+1] <= cx[i]; cy[i+1] <= cy[i]; ct[i+1] <= ct[i];
      end else if (ct[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        ct[i+1] <= ct[i] - atn;
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        ct[i+1] <= ct[i] + atn;
      end
    end
  end

  // stage a: round sin/cos, products for cross and dot
  logic signed [33:0] cc, ss;
  always_comb begin
    cc = cf[N] ? -cx[N] : cx[N];
    ss = cf[N] ? -cy[N] : cy[N];
  end
  logic va;
  logic signed [19:0] c16a, s16a;
  item_t ita;
  logic signed [PW-1:0] pa [6];
  logic signed [PW-1:0] da [3];
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= cv[N];
    ita <= ci[N];
    c16a <= 20'((cc + 34'sd8192) >>> 14);
    s16a <= 20'((ss + 34'sd8192) >>> 14);
    pa[0] <= PW'($signed(ci[N].z[1])) * PW'($signed(ci[N].v[2]));
    pa[1] <= PW'($signed(ci[N].z[2])) * PW'($signed(ci[N].v[1]));
    pa[2] <= PW'($signed(ci[N].z[2])) * PW'($signed(ci[N].v[0]));
    pa[3] <= PW'($signed(ci[N].z[0])) * PW'($signed(ci[N].v[2]));
    pa[4] <= PW'($signed(ci[N].z[0])) * PW'($signed(ci[N].v[1]));
    pa[5] <= PW'($signed(ci[N].z[1])) * PW'($signed(ci[N].v[0]));
    for (int j = 0; j < 3; j++) begin
      da[j] <= PW'($signed(ci[N].z[j])) * PW'($signed(ci[N].v[j]));
    end
  end

  // stage b: round cross and dot
  logic vb;
  logic signed [19:0] c16b, s16b;
  item_t itb;
  logic signed [W+4:0] crb [3];
  logic signed [W+4:0] dotb;
  logic signed [PW+1:0] dsum;
  always_comb dsum = (PW+2)'(da[0]) + (PW+2)'(da[1]) + (PW+2)'(da[2]) + (PW+2)'(8192);
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= va;
    itb <= ita; c16b <= c16a; s16b <= s16a;
    crb[0] <= (W+5)'(((PW+1)'(pa[0]) - (PW+1)'(pa[1]) + (PW+1)'(8192)) >>> 14);
    crb[1] <= (W+5)'(((PW+1)'(pa[2]) - (PW+1)'(pa[3]) + (PW+1)'(8192)) >>> 14);
    crb[2] <= (W+5)'(((PW+1)'(pa[4]) - (PW+1)'(pa[5]) + (PW+1)'(8192)) >>> 14);
    dotb <= (W+5)'(dsum >>> 14);
  end

  // stage c: k and the cos/sin products
  logic vc;
  item_t itc;
  logic signed [W+6:0] kc;
  logic signed [RW-1:0] pc [3];
  logic signed [RW-1:0] sc [3];
  logic signed [W+25:0] kprod;
  always_comb kprod = (W+26)'(dotb) * (W+26)'(21'sd65536 - 21'(c16b)) + (W+26)'(32768);
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else vc <= vb;
    itc <= itb;
    kc <= (W+7)'(kprod >>> 16);
    for (int j = 0; j < 3; j++) begin
      pc[j] <= RW'(c16b) * RW'($signed(itb.v[j]));
      sc[j] <= RW'(s16b) * RW'(crb[j]);
    end
  end

  // stage d: k*z term, sum, round, saturate
  logic signed [RW+1:0] rsum [3];
  logic signed [RW+1:0] rr [3];
  logic [2:0] hi_ov, lo_ov;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rsum[j] = (RW+2)'(pc[j]) + (RW+2)'(sc[j])
              + (((RW+2)'(kc) * (RW+2)'($signed(itc.z[j]))) <<< 2) + (RW+2)'(32768);
      rr[j] = rsum[j] >>> 16;
      hi_ov[j] = rr[j] > (RW+2)'((64'sd1 <<< (W-1)) - 1);
      lo_ov[j] = rr[j] < -(RW+2)'(64'sd1 <<< (W-1));
    end
  end
  logic signed [W-1:0] rd [3];
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vc;
    for (int j = 0; j < 3; j++) begin
      if (hi_ov[j]) rd[j] <= {1'b0, {(W-1){1'b1}}};
      else if (lo_ov[j]) rd[j] <= {1'b1, {(W-1){1'b0}}};
      else rd[j] <= W'(rr[j]);
    end
    clipped <= |(hi_ov | lo_ov);
  end
  assign rot_x = rd[0];
  assign rot_y = rd[1];
  assign rot_z = rd[2];

  a_latency: assert property (@(posedge clk) disable iff (rst)
    va |-> ##3 done) else $error("result lost in pipeline");
  a_order: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vc)) else $error("result without request");
  a_fold: assert property (@(posedge clk) disable iff (rst)
    v0 |-> (t0 <= HalfPiQ30 && t0 >= -HalfPiQ30)) else $error("angle fold out of range");
endmodule
`default_nettype wire

// ===== tb/sv/axis_angle_vector_rotation_tb.sv =====
`default_nettype none
module axis_angle_vector_rotation_tb;
  import aavr_pkg::*;

  localparam int Stages = 16;
  localparam int VecW = 24;
  localparam int Latency = Stages + 5;

  typedef struct {
    logic signed [15:0] ax, ay, az, ang;
    logic signed [VecW-1:0] vx, vy, vz;
  } rot_req_t;

  typedef struct {
    logic signed [VecW-1:0] rx, ry, rz;
    logic clip;
  } rot_res_t;

  logic clk, rst, start, busy, done, clipped;
  logic signed [15:0] axis_x, axis_y, axis_z, angle;
  logic signed [VecW-1:0] vec_x, vec_y, vec_z, rot_x, rot_y, rot_z;

  rot_req_t pending_q[$];
  rot_res_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_clipped = 0;
  int n_requests = 0;
  bit hold_off = 0;
  bit calm = 0;
  bit stim_done = 0;
  int gap_left = 0;

  axis_angle_vector_rotation #(.CORDIC_STAGES(Stages), .VEC_WIDTH(VecW)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .done(done), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .clipped(clipped)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic rot_res_t rotate_vector(rot_req_t r);
    longint z[3], v[3], cr[3], o[3];
    longint t, x, y, nx, c16, s16, dot, k, hi, lo;
    bit flip;
    rot_res_t res;
    z[0] = r.ax; z[1] = r.ay; z[2] = r.az;
    v[0] = r.vx; v[1] = r.vy; v[2] = r.vz;
    hi = (longint'(1) <<< (VecW - 1)) - 1;
    lo = -(longint'(1) <<< (VecW - 1));
    flip = 0;
    t = longint'(r.ang) * 131072;
    if (t > longint'(HalfPiQ30)) begin
      t -= longint'(PiQ30);
      flip = 1;
    end else if (t < -longint'(HalfPiQ30)) begin
      t += longint'(PiQ30);
      flip = 1;
    end
    x = longint'(CordicGain);
    y = 0;
    for (int i = 0; i < Stages && i < AtanEntries; i++) begin
      if (t >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        t -= longint'(atan_q30(i));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        t += longint'(atan_q30(i));
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c16 = rnd_shift(x, 14);
    s16 = rnd_shift(y, 14);
    cr[0] = rnd_shift(z[1] * v[2] - z[2] * v[1], 14);
    cr[1] = rnd_shift(z[2] * v[0] - z[0] * v[2], 14);
    cr[2] = rnd_shift(z[0] * v[1] - z[1] * v[0], 14);
    dot = rnd_shift(z[0] * v[0] + z[1] * v[1] + z[2] * v[2], 14);
    k = rnd_shift(dot * (65536 - c16), 16);
    res.clip = 0;
    for (int j = 0; j < 3; j++) begin
      o[j] = rnd_shift(c16 * v[j] + s16 * cr[j] + 4 * (k * z[j]), 16);
      if (o[j] > hi) begin
        o[j] = hi;
        res.clip = 1;
      end else if (o[j] < lo) begin
        o[j] = lo;
        res.clip = 1;
      end
    end
    res.rx = o[0][VecW-1:0];
    res.ry = o[1][VecW-1:0];
    res.rz = o[2][VecW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [15:0] unit_comp();
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [VecW-1:0] rand_vec();
    case ($urandom_range(0, 3))
      0: return VecW'($urandom_range(0, 2000)) - VecW'(1000);
      1: return $urandom_range(0, 1) ? {1'b0, {(VecW-1){1'b1}}} : {1'b1, {(VecW-1){1'b0}}};
      default: return VecW'($urandom);
    endcase
  endfunction

  task automatic add_request(logic signed [15:0] ax, ay, az, ang,
                             logic signed [VecW-1:0] vx, vy, vz);
    rot_req_t r;
    r.ax = ax; r.ay = ay; r.az = az; r.ang = ang;
    r.vx = vx; r.vy = vy; r.vz = vz;
    pending_q.push_back(r);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst || hold_off || pending_q.size() == 0) begin
      start <= 0;
    end else if (gap_left > 0) begin
      start <= 0;
      gap_left <= gap_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      start <= 0;
      gap_left <= $urandom_range(0, 9);
    end else begin
      rot_req_t r;
      r = pending_q[0];
      start <= 1;
      axis_x <= r.ax; axis_y <= r.ay; axis_z <= r.az; angle <= r.ang;
      vec_x <= r.vx; vec_y <= r.vy; vec_z <= r.vz;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      expected_q.push_back(rotate_vector(pending_q.pop_front()));
      n_requests++;
    end
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        rot_res_t e;
        e = expected_q.pop_front();
        n_results++;
        if (e.clip) n_clipped++;
        if (rot_x !== e.rx) report_mismatch("rot_x", rot_x, e.rx);
        if (rot_y !== e.ry) report_mismatch("rot_y", rot_y, e.ry);
        if (rot_z !== e.rz) report_mismatch("rot_z", rot_z, e.rz);
        if (clipped !== e.clip) report_mismatch("clipped", clipped, e.clip);
      end
    end
  end

  initial begin
    logic signed [VecW-1:0] vmax, vmin;
    vmax = {1'b0, {(VecW-1){1'b1}}};
    vmin = {1'b1, {(VecW-1){1'b0}}};
    rst = 1; start = 0;
    axis_x = 0; axis_y = 0; axis_z = 0; angle = 0;
    vec_x = 0; vec_y = 0; vec_z = 0;
    // directed: axes, angle extremes, non-unit axis, full code range, saturation
    add_request(16384, 0, 0, 0, 1000, -2000, 3000);
    add_request(0, 0, 16384, 12868, 100000, 0, 0);
    add_request(0, 16384, 0, -12868, 0, 0, 100000);
    add_request(0, 0, 16384, 25736, 5000, 7000, -9000);
    add_request(0, 0, 16384, -25736, 5000, 7000, -9000);
    add_request(16384, 0, 0, 12869, vmax, vmax, vmax);
    add_request(-16384, 0, 0, -12869, vmin, vmin, vmin);
    add_request(-32768, -32768, -32768, 0, vmax, vmin, vmax);
    add_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, vmax, vmax, vmax);
    add_request(16'h8000, 16'h7fff, 0, 16'h8000, vmin, vmax, 0);
    add_request(9459, 9459, 9459, 8579, vmax, vmin, 12345);
    add_request(0, 0, 0, 1000, vmax, vmin, -1);
    add_request(11585, -11585, 0, -17000, -1, 1, 0);
    add_request(0, 0, -16384, 30000, vmin, 0, vmax);
    add_request(16384, 0, 0, 1, 0, 0, 0);
    add_request(0, 16384, 0, -1, -1, -1, -1);
    repeat (4) @(posedge clk);
    rst <= 0;
    for (int i = 0; i < 550; i++) begin
      if (i == 300) begin
        wait (pending_q.size() == 0);
        @(negedge clk);
        hold_off = 1;
        wait (expected_q.size() == 0);
        @(negedge clk);
        hold_off = 0;
      end
      if (i == 450) calm = 1;
      if ($urandom_range(0, 9) == 0)
        add_request(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    rand_vec(), rand_vec(), rand_vec());
      else
        add_request(unit_comp(), unit_comp(), unit_comp(),
                    16'(int'($urandom_range(0, 51472)) - 25736),
                    rand_vec(), rand_vec(), rand_vec());
    end
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (Latency + 5) @(posedge clk);
    $display("%0d rotations sent, %0d results checked, %0d saturated",
             n_requests, n_results, n_clipped);
    $display("covered axis and angle extremes, non-unit axes and full-range codes");
    if (errors == 0 && expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #400000;
    $display("timeout");
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== axis_angle_vector_rotation.f =====
hw/rtl/aavr_pkg.sv
hw/rtl/axis_angle_vector_rotation.sv
tb/sv/axis_angle_vector_rotation_tb.sv
